### rtl/core/lcpu_pkg.sv
// Package: shared widths, item structs, gate approximation and rounding functions.
`default_nettype none
package lcpu_pkg;

  localparam int UNIT_W        = 10;
  localparam int VAL_W         = 16;
  localparam int GATE_W        = 13;   // sigmoid result 0..4096
  localparam int TANH_W        = 14;   // tanh result -4096..4096
  localparam int ACC_W         = 30;
  localparam int DEFAULT_UNITS = 1024;
  localparam int IN_TDATA_W    = 80;   // 74 bits of fields, padded to bytes
  localparam int OUT_TDATA_W   = 48;   // 42 bits of fields, padded to bytes

  typedef struct packed {
    logic                    valid;
    logic [UNIT_W-1:0]       unit;
    logic signed [VAL_W-1:0] cell_val;
    logic [GATE_W-1:0]       og;
  } cell_item_t;

  typedef struct packed {
    logic                    valid;
    logic [UNIT_W-1:0]       unit;
    logic signed [VAL_W-1:0] cell_val;
    logic signed [VAL_W-1:0] hidden;
  } result_t;

  // Piecewise-linear sigmoid on a Q12 value of up to 17 bits.
  function automatic logic [GATE_W-1:0] plan_sigmoid(input logic signed [16:0] x);
    logic signed [17:0] xe;
    logic [17:0]        a;
    logic [GATE_W-1:0]  y;
    xe = 18'(x);
    a  = xe[17] ? 18'(-xe) : 18'(xe);
    if (a >= 18'd20480) begin
      y = 13'd4096;
    end else if (a >= 18'd9728) begin
      y = 13'(a >> 5) + 13'd3456;
    end else if (a >= 18'd4096) begin
      y = 13'(a >> 3) + 13'd2560;
    end else begin
      y = 13'(a >> 2) + 13'd2048;
    end
    return x[16] ? 13'd4096 - y : y;
  endfunction

  function automatic logic [GATE_W-1:0] gate_sigmoid(input logic signed [VAL_W-1:0] x);
    return plan_sigmoid({x[VAL_W-1], x});
  endfunction

  // tanh(x) = 2*sigmoid(2x) - 1
  function automatic logic signed [TANH_W-1:0] approx_tanh(input logic signed [VAL_W-1:0] x);
    logic [GATE_W-1:0]  s;
    logic signed [14:0] t;
    s = plan_sigmoid({x, 1'b0});
    t = $signed({1'b0, s, 1'b0}) - 15'sd4096;
    return t[TANH_W-1:0];
  endfunction

  // Q6.24 to Q4.12, round half up, saturate to 16 bits.
  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] sh;
    logic signed [17:0]      r;
    t  = acc + 30'sd2048;
    sh = t >>> 12;
    r  = sh[17:0];
    if (r > 18'sd32767) begin
      return 16'sh7fff;
    end else if (r < -18'sd32768) begin
      return 16'sh8000;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/lcpu_cell_path.sv
// Cell path: gate activations, cell store with forwarding, cell recurrence.
`default_nettype none
module lcpu_cell_path #(
  parameter int UNITS = lcpu_pkg::DEFAULT_UNITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [lcpu_pkg::UNIT_W-1:0]    unit_index,
  input  logic                           seq_continue,
  input  logic signed [lcpu_pkg::VAL_W-1:0] input_gate_pre,
  input  logic signed [lcpu_pkg::VAL_W-1:0] forget_gate_pre,
  input  logic signed [lcpu_pkg::VAL_W-1:0] output_gate_pre,
  input  logic signed [lcpu_pkg::VAL_W-1:0] candidate_pre,
  output lcpu_pkg::cell_item_t           cell_item
);
  import lcpu_pkg::*;

  localparam int SLOT_W = (UNITS > 1) ? $clog2(UNITS) : 1;

  // stage 1
  logic                     v1;
  logic [UNIT_W-1:0]        unit1;
  logic                     cont1;
  logic [GATE_W-1:0]        ig1, fg1, og1;
  logic signed [TANH_W-1:0] gg1;
  logic [SLOT_W-1:0]        slot1;
  // stage 2
  logic                     v2;
  logic [UNIT_W-1:0]        unit2;
  logic                     cont2;
  logic [GATE_W-1:0]        fg2, og2;
  logic signed [27:0]       pig2;
  logic [SLOT_W-1:0]        slot2;
  logic signed [VAL_W-1:0]  rd_q;
  // stage 3
  logic                     v3;
  logic [UNIT_W-1:0]        unit3;
  logic [GATE_W-1:0]        og3;
  logic signed [VAL_W-1:0]  cell3;
  logic [SLOT_W-1:0]        slot3;

  logic signed [VAL_W-1:0]  mem [UNITS];
  logic signed [VAL_W-1:0]  cprev;
  logic signed [29:0]       pfc;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VAL_W-1:0]  cell_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit1 <= unit_index;
      cont1 <= seq_continue;
      ig1   <= gate_sigmoid(input_gate_pre);
      fg1   <= gate_sigmoid(forget_gate_pre);
      og1   <= gate_sigmoid(output_gate_pre);
      gg1   <= approx_tanh(candidate_pre);

      unit2 <= unit1;
      cont2 <= cont1;
      fg2   <= fg1;
      og2   <= og1;
      pig2  <= $signed({1'b0, ig1}) * gg1;
      slot2 <= slot1;

      unit3 <= unit2;
      og3   <= og2;
      cell3 <= cell_new;
      slot3 <= slot2;
    end
  end

  // slot = unit mod UNITS
  generate
    if (UNITS >= 1024) begin : g_direct
      assign slot1 = SLOT_W'(unit1);
    end else begin : g_recip
      localparam int RECIP = ((1 << 20) + UNITS - 1) / UNITS;
      logic [30:0] qprod;
      logic [9:0]  q1;
      logic [19:0] qm;
      logic [9:0]  rem;
      assign qprod = 31'(unit_index) * 31'(RECIP);
      always_ff @(posedge clk) begin
        if (en) begin
          q1 <= qprod[29:20];
        end
      end
      assign qm    = 20'(q1) * 20'(UNITS);
      assign rem   = unit1 - qm[9:0];
      assign slot1 = SLOT_W'(rem);
    end
  endgenerate

  // store: read for stage 1 item, write from stage 2 item
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q <= mem[slot1];
      if (v2) begin
        mem[slot2] <= cell_new;
      end
    end
  end

  // the item one ahead wrote on the same edge as our read
  always_comb begin
    if (!cont2) begin
      cprev = '0;
    end else if (v3 && (slot3 == slot2)) begin
      cprev = cell3;
    end else begin
      cprev = rd_q;
    end
  end

  assign pfc      = $signed({1'b0, fg2}) * cprev;
  assign acc      = {{2{pig2[27]}}, pig2} + pfc;
  assign cell_new = round_sat(acc);

  assign cell_item = '{valid: v3, unit: unit3, cell_val: cell3, og: og3};

endmodule
`default_nettype wire

### rtl/core/lcpu_hidden_path.sv
// Hidden path: tanh of the cell, output gate product, rounding.
`default_nettype none
module lcpu_hidden_path (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  lcpu_pkg::cell_item_t cell_item,
  output lcpu_pkg::result_t    result
);
  import lcpu_pkg::*;

  logic                     v4, v5;
  logic [UNIT_W-1:0]        unit4, unit5;
  logic signed [VAL_W-1:0]  cell4, cell5;
  logic [GATE_W-1:0]        og4;
  logic signed [TANH_W-1:0] th4;
  logic signed [27:0]       prod5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= cell_item.valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit4 <= cell_item.unit;
      cell4 <= cell_item.cell_val;
      og4   <= cell_item.og;
      th4   <= approx_tanh(cell_item.cell_val);
      unit5 <= unit4;
      cell5 <= cell4;
      prod5 <= $signed({1'b0, og4}) * th4;
    end
  end

  assign result = '{valid: v5, unit: unit5, cell_val: cell5,
                    hidden: round_sat({{2{prod5[27]}}, prod5})};

endmodule
`default_nettype wire

### rtl/core/lcpu_out_buf.sv
// Output register with skid entry; pipeline advances while the skid is empty.
`default_nettype none
module lcpu_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  lcpu_pkg::result_t result,
  output logic              en,
  output logic              out_valid,
  input  logic              out_ready,
  output lcpu_pkg::result_t out_item
);
  import lcpu_pkg::*;

  logic    skid_valid;
  result_t skid;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= result.valid;
    end else if (result.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_item <= skid;
      end
    end else if (!out_valid || out_ready) begin
      out_item <= result;
    end else begin
      skid <= result;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lstm_cell_pointwise_update_core.sv
// Top level: LSTM cell pointwise update, streaming in and out.
`default_nettype none
// One transaction in carries one hidden unit's four gate pre-activations (Q4.12);
// one transaction out carries its new cell value (saturated Q4.12) and hidden
// value o*tanh(c). A new transaction is taken every cycle while s_axis_tready
// is high. The recurrence c = i*g + f*c_prev closes in a single stage, with
// the preceding transaction's cell forwarded when consecutive transactions
// hit the same store slot. Stalls on the output side are absorbed by one skid
// entry before the input is held off. The cell store is a UNITS-deep memory
// indexed by unit_index modulo UNITS; an entry must be written (seq_continue
// low) before it is read. No clearing pass after reset.
module lstm_cell_pointwise_update_core #(
  parameter int UNITS = lcpu_pkg::DEFAULT_UNITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] unit_index, [25:10] input_gate_pre, [41:26] forget_gate_pre,
  // [57:42] output_gate_pre, [73:58] candidate_pre, [79:74] zero
  input  logic [lcpu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] seq_continue
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] unit_out, [25:10] cell_out, [41:26] hidden_out, [47:42] zero
  output logic [lcpu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import lcpu_pkg::*;

  logic       en;
  cell_item_t cell_item;
  result_t    result;
  result_t    out_item;

  lcpu_cell_path #(.UNITS(UNITS)) u_cell (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_axis_tvalid),
    .unit_index      (s_axis_tdata[9:0]),
    .seq_continue    (s_axis_tuser),
    .input_gate_pre  (s_axis_tdata[25:10]),
    .forget_gate_pre (s_axis_tdata[41:26]),
    .output_gate_pre (s_axis_tdata[57:42]),
    .candidate_pre   (s_axis_tdata[73:58]),
    .cell_item       (cell_item)
  );

  lcpu_hidden_path u_hidden (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cell_item (cell_item),
    .result    (result)
  );

  lcpu_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .en        (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = {6'd0, out_item.hidden, out_item.cell_val, out_item.unit};

  // input is held off only while an output transaction is pending
  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off without a pending output transaction");

  a_fall_after_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("ready dropped without an output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### dv/lcpu_update_checker.sv
// Checker: predicts each unit's cell and hidden value and compares the output stream.
`timescale 1ns / 1ps
module lcpu_update_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [lcpu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [lcpu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output int                                fail_count,
  output int                                pending_count
);
  import lcpu_pkg::*;

  // first member lands in the top bits: hidden, cell, unit from the top down
  typedef struct packed {
    logic signed [VAL_W-1:0] hidden;
    logic signed [VAL_W-1:0] cell_val;
    logic [UNIT_W-1:0]       unit;
  } unit_update_t;

  logic signed [VAL_W-1:0] cell_mem [1024];
  unit_update_t            expected_updates [$];

  function automatic int sig_q12(int x);
    int a;
    int y;
    a = (x < 0) ? -x : x;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = (a >>> 5) + 3456;
    else if (a >= 4096) y = (a >>> 3) + 2560;
    else y = (a >>> 2) + 2048;
    return (x < 0) ? 4096 - y : y;
  endfunction

  function automatic int tanh_q12(int x);
    return 2 * sig_q12(2 * x) - 4096;
  endfunction

  // round half up to Q12 (floor after +2048), then saturate
  function automatic logic signed [VAL_W-1:0] q24_to_q12(longint v);
    longint r;
    r = (v + 2048) >>> 12;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[VAL_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    unit_update_t exp_u;
    unit_update_t got_u;
    int           ig, fg, og, gg, cprev;
    logic [UNIT_W-1:0] unit;
    if (rst) begin
      fail_count = 0;
      expected_updates.delete();
      pending_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        unit  = s_axis_tdata[9:0];
        ig    = sig_q12(int'($signed(s_axis_tdata[25:10])));
        fg    = sig_q12(int'($signed(s_axis_tdata[41:26])));
        og    = sig_q12(int'($signed(s_axis_tdata[57:42])));
        gg    = tanh_q12(int'($signed(s_axis_tdata[73:58])));
        cprev = s_axis_tuser ? int'(cell_mem[unit]) : 0;
        exp_u.unit     = unit;
        exp_u.cell_val = q24_to_q12(longint'(ig) * gg + longint'(fg) * cprev);
        exp_u.hidden   = q24_to_q12(longint'(og) * tanh_q12(int'(exp_u.cell_val)));
        cell_mem[unit] = exp_u.cell_val;
        expected_updates.push_back(exp_u);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_u = m_axis_tdata[41:0];
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected transaction, unit", got_u.unit, -1);
        end else begin
          exp_u = expected_updates.pop_front();
          if (got_u.unit !== exp_u.unit)
            report_mismatch("unit_out", got_u.unit, exp_u.unit);
          if (got_u.cell_val !== exp_u.cell_val)
            report_mismatch("cell_out", got_u.cell_val, exp_u.cell_val);
          if (got_u.hidden !== exp_u.hidden)
            report_mismatch("hidden_out", got_u.hidden, exp_u.hidden);
        end
      end
      pending_count = expected_updates.size();
    end
  end
endmodule

### dv/tb_lstm_cell_pointwise_update_core.sv
// Testbench top: drives unit updates with random idling and gives the verdict.
`timescale 1ns / 1ps
module tb_lstm_cell_pointwise_update_core;
  import lcpu_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     fail_count;
  int                     pending_count;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  written [1024];   // units whose cell has been stored at least once

  lstm_cell_pointwise_update_core u_dut (.*);

  lcpu_update_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One transaction; continue is forced low on a never-written unit.
  // Returns at the falling edge after acceptance with tvalid still high.
  task automatic send_update(logic [9:0] unit, logic cont, logic [15:0] ig,
                             logic [15:0] fg, logic [15:0] og, logic [15:0] cg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cont & written[unit];
    s_axis_tdata  <= {6'd0, cg, og, fg, ig, unit};
    written[unit] = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_pre();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(12000)) - 6000);   // knee region
      2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(50000)) - 25000);
    endcase
  endfunction

  initial begin
    logic [15:0] ext [6];
    logic [9:0]  u;
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000, 16'hf000, 16'h2600};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: start of sequence, then cell growth on the same unit, then unit 1023 and extremes on units 2 to 7
    send_update(10'd0, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    for (int k = 0; k < 6; k++)
      send_update(10'd0, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_update(10'd1023, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_update(10'd1023, 1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    for (int k = 0; k < 6; k++)
      send_update(10'(k + 2), 1'b0, ext[k], ext[(k+1)%6], ext[(k+2)%6], ext[(k+3)%6]);
    for (int k = 0; k < 6; k++)
      send_update(10'(k + 2), 1'b1, ext[(k+3)%6], ext[k], ext[(k+4)%6], ext[(k+5)%6]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 8 : 0;
      for (int n = 0; n < 400; n++) begin
        // small hot set of units so continues and back-to-back hits are common
        u = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
        send_update(u, ($urandom_range(4) != 0), rand_pre(), rand_pre(), rand_pre(),
                    rand_pre());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
